FILE: rtl/sgs_pkg.sv
// sgs_pkg: shared types and constants for the sobel gradient stream unit
// no dependencies; imported by every module of the block
`default_nettype none

package sgs_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 12;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  // reset values of the frame registers
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1080);

  // register index, taken from paddr bit 2
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // one entry of the line memory: row-2 and row-1 pixels of a column
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
  } line_pair_t;

  // fetched item handed from the fetch stage to the gradient stage
  typedef struct packed {
    logic             valid;
    logic             res;
    logic             last;
    logic [PIX_W-1:0] px;
    line_pair_t       lines;
  } stage_t;

endpackage

`default_nettype wire

FILE: rtl/sobel_gradient_stream_unit.sv
// sobel_gradient_stream_unit: top level of the streaming 3x3 sobel gradient block
// depends on sgs_pkg, sgs_cfg, sgs_fetch, sgs_grad
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   in_pixel (8 bit unsigned)
//   out       output     out_valid / out_ready out_grad_x, out_grad_y (11 bit signed),
//                                              out_frame_end
//   cfg       input      APB psel / penable    frame_width @0x0, frame_height @0x4
//
// one pixel per cycle sustained while the output is not stalled; a result passes from its
// pixel transaction through the line memory read register, then the result register
// the line memory has one write and one read per cycle, which sets the rate
// reset is synchronous and active low; the line memory is not cleared
// a stalled result blocks the fetch stage only when the held pixel has a result
`default_nettype none

module sobel_gradient_stream_unit import sgs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic      [PDATA_W-1:0]       prdata,
  output logic                          pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [PIX_W-1:0]         in_pixel,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [GRAD_W-1:0]      out_grad_x,
  output logic signed [GRAD_W-1:0]      out_grad_y,
  output logic                          out_frame_end
);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  stage_t           stage;
  logic             take;

  // configuration registers
  sgs_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  // counters and line memory
  sgs_fetch u_fetch (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .take         (take),
    .stage        (stage)
  );

  // window and gradients
  sgs_grad u_grad (
    .clk           (clk),
    .rst_n         (rst_n),
    .stage         (stage),
    .take          (take),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_grad_x    (out_grad_x),
    .out_grad_y    (out_grad_y),
    .out_frame_end (out_frame_end)
  );

  // an empty fetch stage always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !stage.valid |-> in_ready)
    else $error("input not ready with empty fetch stage");

  // a new result only comes from a fetched pixel that has one
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(stage.valid && stage.res))
    else $error("result appeared without a source pixel");

  // a blocked result holds back the pixel waiting behind it
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && stage.res && out_valid && !out_ready |-> !in_ready && !take)
    else $error("fetch stage advanced into a full result register");

endmodule

`default_nettype wire

FILE: rtl/sgs_cfg.sv
// sgs_cfg: APB-style register file holding frame width and height
// depends on sgs_pkg
`default_nettype none

module sgs_cfg import sgs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output logic      [CFG_W-1:0]   frame_width,
  output logic      [CFG_W-1:0]   frame_height
);

  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic             wr_en;
  reg_idx_t         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIDTH:  width_r  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: height_r <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_WIDTH:  prdata = {{(PDATA_W-CFG_W){1'b0}}, width_r};
      REG_HEIGHT: prdata = {{(PDATA_W-CFG_W){1'b0}}, height_r};
      default:    prdata = '0;
    endcase
  end

  assign frame_width  = width_r;
  assign frame_height = height_r;

endmodule

`default_nettype wire

FILE: rtl/sgs_fetch.sv
// sgs_fetch: raster counters, line memory and the fetch register stage
// depends on sgs_pkg
`default_nettype none

module sgs_fetch import sgs_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] frame_width,
  input  wire logic [CFG_W-1:0] frame_height,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [PIX_W-1:0] in_pixel,
  input  wire logic             take,
  output stage_t                stage
);

  localparam int DEPTH = MAX_WIDTH;

  line_pair_t       mem [DEPTH];
  line_pair_t       rd_r;
  line_pair_t       wr_data;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [CFG_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] addr_r;
  logic [PIX_W-1:0] px_r;
  logic             valid_r, valid_nxt;
  logic             res_r;
  logic             last_r;
  logic [CFG_W-1:0] ew;
  logic [CFG_W-1:0] eh;
  logic             row_last;
  logic             frame_last;
  logic             has_res;
  logic             accept;

  assign in_ready = !valid_r || take;
  assign accept   = in_valid && in_ready;

  // effective frame size: width capped at the line length, zero read as one
  always_comb begin
    if (32'(frame_width) > MAX_WIDTH) begin
      ew = CFG_W'(MAX_WIDTH);
    end else if (frame_width == '0) begin
      ew = CFG_W'(1);
    end else begin
      ew = frame_width;
    end
    eh = (frame_height == '0) ? CFG_W'(1) : frame_height;
  end

  // position flags of the incoming pixel
  assign row_last   = 32'(col_r) >= 32'(ew) - 32'd1;
  assign frame_last = row_last && (row_r >= eh - CFG_W'(1));
  assign has_res    = (32'(col_r) >= 32'd2) && (row_r >= CFG_W'(2));

  // next column and row
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (row_last) begin
        col_nxt = '0;
        row_nxt = frame_last ? '0 : row_r + CFG_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  // stage occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= col_r;
      px_r   <= in_pixel;
      res_r  <= has_res;
      last_r <= frame_last;
    end
  end

  // line memory: column shifts up by one row when its item leaves the stage
  assign wr_data = '{top: rd_r.mid, mid: px_r};

  always_ff @(posedge clk) begin
    if (take) begin
      mem[addr_r] <= wr_data;
    end
  end

  // registered read, with bypass of a write to the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      if (take && (addr_r == col_r)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= mem[col_r];
      end
    end
  end

  assign stage = '{valid: valid_r, res: res_r, last: last_r, px: px_r, lines: rd_r};

endmodule

`default_nettype wire

FILE: rtl/sgs_grad.sv
// sgs_grad: 3x3 window columns, sobel gradients and the result register
// depends on sgs_pkg
`default_nettype none

module sgs_grad import sgs_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire stage_t                   stage,
  output logic                          take,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [GRAD_W-1:0]      out_grad_x,
  output logic signed [GRAD_W-1:0]      out_grad_y,
  output logic                          out_frame_end
);

  // window columns, rows top, mid, bottom; col2 is column x-2, col1 is x-1
  logic [PIX_W-1:0] c2_r [3];
  logic [PIX_W-1:0] c1_r [3];
  logic signed [GRAD_W-1:0] l0, l1, l2, m0, m2, n0, n1, n2;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [GRAD_W-1:0] gx_r, gy_r;
  logic             end_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;
  assign take     = stage.valid && (!stage.res || out_free);

  // widen window values to signed
  assign l0 = $signed({{(GRAD_W-PIX_W){1'b0}}, c2_r[0]});
  assign l1 = $signed({{(GRAD_W-PIX_W){1'b0}}, c2_r[1]});
  assign l2 = $signed({{(GRAD_W-PIX_W){1'b0}}, c2_r[2]});
  assign m0 = $signed({{(GRAD_W-PIX_W){1'b0}}, c1_r[0]});
  assign m2 = $signed({{(GRAD_W-PIX_W){1'b0}}, c1_r[2]});
  assign n0 = $signed({{(GRAD_W-PIX_W){1'b0}}, stage.lines.top});
  assign n1 = $signed({{(GRAD_W-PIX_W){1'b0}}, stage.lines.mid});
  assign n2 = $signed({{(GRAD_W-PIX_W){1'b0}}, stage.px});

  // right minus left, bottom minus top, centre weight two
  assign gx = (n0 - l0) + ((n1 - l1) <<< 1) + (n2 - l2);
  assign gy = (l2 - l0) + ((m2 - m0) <<< 1) + (n2 - n0);

  // window shifts on every pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        c2_r[i] <= '0;
        c1_r[i] <= '0;
      end
    end else if (take) begin
      c2_r    <= c1_r;
      c1_r[0] <= stage.lines.top;
      c1_r[1] <= stage.lines.mid;
      c1_r[2] <= stage.px;
    end
  end

  // result register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && stage.res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && stage.res) begin
      gx_r  <= gx;
      gy_r  <= gy;
      end_r <= stage.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_grad_x    = gx_r;
  assign out_grad_y    = gy_r;
  assign out_frame_end = end_r;

endmodule

`default_nettype wire
